// ===== sv/cbz_pkg.sv =====
// Shared types and constants for the cubic Bezier inverse-by-bisection unit.
package cbz_pkg;

    // Fixed field widths
    localparam int unsigned CTRL_W      = 32;
    localparam int unsigned TOL_W       = 16;
    localparam int unsigned T_OUT_W     = 16;
    localparam int unsigned STEPS_OUT_W = 5;
    localparam int unsigned CFG_IDX_W   = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd4;

    // Register reset values
    localparam logic [CTRL_W-1:0] RST_CTRL_START = 32'd0;
    localparam logic [CTRL_W-1:0] RST_CTRL_ONE   = 32'd0;
    localparam logic [CTRL_W-1:0] RST_CTRL_TWO   = 32'd65536;
    localparam logic [CTRL_W-1:0] RST_CTRL_END   = 32'd65536;
    localparam logic [TOL_W-1:0]  RST_TOLERANCE  = 16'd7;

    // Sequencer states: idle, one state per datapath stage of a bisection step, and output load
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_CUBE,
        ST_PROD,
        ST_ACC,
        ST_FIN
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic sq_en;
        logic cube_en;
        logic prod_en;
        logic acc_en;
        logic out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic hit;
        logic last;
    } t_status;

endpackage

// ===== sv/cbz_ctrl.sv =====
// Sequencer for the bisection steps and the output register handshake.
module cbz_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    input  cbz_pkg::t_status i_status,
    output cbz_pkg::t_cmd    o_cmd
);
    import cbz_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   cmd;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.sq_en = 1'b1;
                n_state   = ST_CUBE;
            end
            ST_CUBE: begin
                cmd.cube_en = 1'b1;
                n_state     = ST_PROD;
            end
            ST_PROD: begin
                cmd.prod_en = 1'b1;
                n_state     = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_en = 1'b1;
                n_state    = (i_status.hit || i_status.last) ? ST_FIN : ST_SQ;
            end
            ST_FIN: begin
                // wait for the output register to be free
                if (!r_out_valid || i_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
            n_out_valid = 1'b1;
        else if (r_out_valid && i_ready)
            n_out_valid = 1'b0;
        else
            n_out_valid = r_out_valid;
    end

    assign o_cmd   = cmd;
    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== sv/cbz_datapath.sv =====
// Datapath: config registers, Bernstein evaluation stages, interval update, result register.
module cbz_datapath #(
    parameter int unsigned T_FRAC_BITS = 16,
    parameter int unsigned MAX_STEPS   = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cbz_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cbz_pkg::CTRL_W-1:0]          i_cfg_data,
    input  logic signed [cbz_pkg::CTRL_W-1:0]   i_target_x,
    input  cbz_pkg::t_cmd                       i_cmd,
    output cbz_pkg::t_status                    o_status,
    output logic [cbz_pkg::T_OUT_W-1:0]         o_t_found,
    output logic                                o_converged,
    output logic [cbz_pkg::STEPS_OUT_W-1:0]     o_steps_used
);
    import cbz_pkg::*;

    localparam int unsigned F    = T_FRAC_BITS;
    localparam int unsigned WX   = F + 3;          // weight width (3x term)
    localparam int unsigned PW   = CTRL_W + WX + 1; // control x weight product
    localparam int unsigned ACCW = PW + 2;
    localparam int unsigned DW   = ACCW + 1;
    localparam int unsigned SW   = $clog2(MAX_STEPS + 1);

    localparam logic [F:0]    ONE      = {1'b1, {F{1'b0}}};
    localparam logic [F-1:0]  HALF     = {1'b1, {(F-1){1'b0}}};
    localparam logic [SW-1:0] LAST_IDX = SW'(MAX_STEPS - 1);

    // Configuration registers
    logic signed [CTRL_W-1:0] r_ctrl_start;
    logic signed [CTRL_W-1:0] r_ctrl_one;
    logic signed [CTRL_W-1:0] r_ctrl_two;
    logic signed [CTRL_W-1:0] r_ctrl_end;
    logic [TOL_W-1:0]         r_tolerance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_start <= RST_CTRL_START;
            r_ctrl_one   <= RST_CTRL_ONE;
            r_ctrl_two   <= RST_CTRL_TWO;
            r_ctrl_end   <= RST_CTRL_END;
            r_tolerance  <= RST_TOLERANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CTRL_START: r_ctrl_start <= i_cfg_data;
                REG_CTRL_ONE:   r_ctrl_one   <= i_cfg_data;
                REG_CTRL_TWO:   r_ctrl_two   <= i_cfg_data;
                REG_CTRL_END:   r_ctrl_end   <= i_cfg_data;
                REG_TOLERANCE:  r_tolerance  <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Search state
    logic signed [CTRL_W-1:0] r_target;
    logic [F:0]    r_lo;
    logic [F:0]    r_hi;
    logic [F-1:0]  r_mid;
    logic [F:0]    r_u;
    logic [F-1:0]  r_tried;
    logic [SW-1:0] r_steps;
    logic          r_hit;

    // Stage registers
    logic [F:0]   r_u2;
    logic [F-1:0] r_t2;
    logic [F:0]   r_u3;
    logic [F-1:0] r_t3;
    logic [F:0]   r_x1;
    logic [F:0]   r_x2;
    logic signed [PW-1:0] r_p0;
    logic signed [PW-1:0] r_p1;
    logic signed [PW-1:0] r_p2;
    logic signed [PW-1:0] r_p3;
    logic [F-1:0] r_mid_dn;
    logic [F-1:0] r_mid_up;

    // Squares
    logic [2*F+1:0] sq_u;
    logic [2*F-1:0] sq_t;
    assign sq_u = (2*F+2)'(r_u) * (2*F+2)'(r_u);
    assign sq_t = (2*F)'(r_mid) * (2*F)'(r_mid);

    // Cubes and cross terms
    logic [2*F+1:0] cb_u;
    logic [2*F-1:0] cb_t;
    logic [2*F:0]   cr_1;
    logic [2*F:0]   cr_2;
    assign cb_u = (2*F+2)'(r_u2) * (2*F+2)'(r_u);
    assign cb_t = (2*F)'(r_t2) * (2*F)'(r_mid);
    assign cr_1 = (2*F+1)'(r_u2) * (2*F+1)'(r_mid);
    assign cr_2 = (2*F+1)'(r_u) * (2*F+1)'(r_t2);

    // Weights times control values
    logic [WX-1:0] w0;
    logic [WX-1:0] w1;
    logic [WX-1:0] w2;
    logic [WX-1:0] w3;
    logic signed [PW-1:0] pr0;
    logic signed [PW-1:0] pr1;
    logic signed [PW-1:0] pr2;
    logic signed [PW-1:0] pr3;
    logic [F+1:0] sum_dn;
    logic [F+1:0] sum_up;
    assign w0 = WX'(r_u3);
    assign w1 = (WX'(r_x1) << 1) + WX'(r_x1);
    assign w2 = (WX'(r_x2) << 1) + WX'(r_x2);
    assign w3 = WX'(r_t3);
    assign pr0 = r_ctrl_start * $signed({1'b0, w0});
    assign pr1 = r_ctrl_one   * $signed({1'b0, w1});
    assign pr2 = r_ctrl_two   * $signed({1'b0, w2});
    assign pr3 = r_ctrl_end   * $signed({1'b0, w3});
    // candidate midpoints of the two halves
    assign sum_dn = {1'b0, r_lo} + {2'b00, r_mid};
    assign sum_up = {2'b00, r_mid} + {1'b0, r_hi};

    // Sum, floor, error and compare
    logic signed [ACCW-1:0] acc;
    logic signed [ACCW-1:0] val;
    logic signed [DW-1:0]   diff;
    logic signed [DW-1:0]   tol_s;
    logic                   gt;
    logic                   hit;
    logic [F-1:0]           next_mid;
    assign acc   = ACCW'(r_p0) + ACCW'(r_p1) + ACCW'(r_p2) + ACCW'(r_p3);
    assign val   = acc >>> F;
    assign diff  = {val[ACCW-1], val} - {{(DW-CTRL_W){r_target[CTRL_W-1]}}, r_target};
    assign tol_s = {{(DW-TOL_W){1'b0}}, r_tolerance};
    assign gt    = !diff[DW-1] && (diff != '0);
    assign hit   = (diff <= tol_s) && (diff >= -tol_s);
    assign next_mid = gt ? r_mid_dn : r_mid_up;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target <= i_target_x;
            r_lo     <= '0;
            r_hi     <= ONE;
            r_mid    <= HALF;
            r_u      <= ONE - {1'b0, HALF};
            r_steps  <= '0;
        end
        if (i_cmd.sq_en) begin
            r_u2 <= sq_u[2*F:F];
            r_t2 <= sq_t[2*F-1:F];
        end
        if (i_cmd.cube_en) begin
            r_u3 <= cb_u[2*F:F];
            r_t3 <= cb_t[2*F-1:F];
            r_x1 <= cr_1[2*F:F];
            r_x2 <= cr_2[2*F:F];
        end
        if (i_cmd.prod_en) begin
            r_p0     <= pr0;
            r_p1     <= pr1;
            r_p2     <= pr2;
            r_p3     <= pr3;
            r_mid_dn <= sum_dn[F:1];
            r_mid_up <= sum_up[F:1];
        end
        if (i_cmd.acc_en) begin
            // keep lower half when the curve lies above the target
            if (gt)
                r_hi <= {1'b0, r_mid};
            else
                r_lo <= {1'b0, r_mid};
            r_mid   <= next_mid;
            r_u     <= ONE - {1'b0, next_mid};
            r_tried <= r_mid;
            r_steps <= r_steps + 1'b1;
            r_hit   <= hit;
        end
    end

    assign o_status.hit  = hit;
    assign o_status.last = (r_steps == LAST_IDX);

    // Result register, midpoint rescaled to Q0.16
    logic [F+15:0]     t_ext;
    logic [SW+4:0]     steps_ext;
    logic [T_OUT_W-1:0]     r_t_found;
    logic                   r_converged;
    logic [STEPS_OUT_W-1:0] r_steps_used;
    assign t_ext     = {r_tried, 16'b0};
    assign steps_ext = {5'b0, r_steps};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_t_found    <= t_ext[F+15:F];
            r_converged  <= r_hit;
            r_steps_used <= steps_ext[STEPS_OUT_W-1:0];
        end
    end

    assign o_t_found    = r_t_found;
    assign o_converged  = r_converged;
    assign o_steps_used = r_steps_used;

endmodule

// ===== sv/cubic_bezier_t_from_x_bisection_unit.sv =====
// Top level of the cubic Bezier inverse-by-bisection unit.
// Finds the curve parameter t (Q0.16) at which a 1-D cubic Bezier, set by four
// control values and a tolerance in the configuration registers, reaches the
// target coordinate. Each bisection step passes through one sequencer state for each
// stage of the multiplier chain (squares, cubes and cross terms, control products, sum
// and compare). An item takes n steps (1 <= n <= MAX_STEPS); its result is then loaded
// into the output register as soon as that register is free or being read, and the next
// item can be taken once the result is loaded, while that result still waits there.
// converged is low when the step cap ended the search.
module cubic_bezier_t_from_x_bisection_unit #(
    parameter int unsigned T_FRAC_BITS = 16,
    parameter int unsigned MAX_STEPS   = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cbz_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cbz_pkg::CTRL_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [cbz_pkg::CTRL_W-1:0]   i_target_x,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [cbz_pkg::T_OUT_W-1:0]         o_t_found,
    output logic                                o_converged,
    output logic [cbz_pkg::STEPS_OUT_W-1:0]     o_steps_used
);
    import cbz_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer
    cbz_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Arithmetic and registers
    cbz_datapath #(
        .T_FRAC_BITS (T_FRAC_BITS),
        .MAX_STEPS   (MAX_STEPS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_target_x   (i_target_x),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_t_found    (o_t_found),
        .o_converged  (o_converged),
        .o_steps_used (o_steps_used)
    );

endmodule
